@@ hw/rtl/spwm_pkg.sv @@
// Shared types, codes and the per-channel level function for the spread PWM.
package spwm_pkg;

    localparam int PORT_W     = 32;
    localparam int SLOT_OUT_W = 6;
    localparam int DUTY_W     = 7;
    localparam int CHAN_W     = 5;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd64;
    localparam logic [2:0]        EXP_CAP   = 3'd6;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_SELECT = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic              buffer_sel;
        logic [CHAN_W-1:0] channel;
        logic [7:0]        duty;
    } t_in_item;

    typedef struct packed {
        logic [PORT_W-1:0]     port_bits;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  frame_used;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic              frame;
        logic [CHAN_W-1:0] channel;
        logic [DUTY_W-1:0] duty;
    } t_duty_wr;

    typedef struct packed {
        logic tick;
        logic select;
        logic target;
    } t_frame_cmd;

    // Level of one channel in one slot. The on-time of duty d is spread over
    // periods of 64 >> ctz(d) slots, ctz capped at six.
    function automatic logic pwm_level(input logic [DUTY_W-1:0]     duty,
                                       input logic [SLOT_OUT_W-1:0] slot);
        logic [2:0]            e;
        logic [SLOT_OUT_W-1:0] mask;
        logic [SLOT_OUT_W-1:0] on_cnt;
        if (duty[0]) begin
            e = 3'd0;
        end else if (duty[1]) begin
            e = 3'd1;
        end else if (duty[2]) begin
            e = 3'd2;
        end else if (duty[3]) begin
            e = 3'd3;
        end else if (duty[4]) begin
            e = 3'd4;
        end else if (duty[5]) begin
            e = 3'd5;
        end else begin
            e = EXP_CAP;
        end
        mask   = 6'h3f >> e;
        on_cnt = duty[SLOT_OUT_W-1:0] >> e;
        return (duty >= DUTY_FULL) || ((slot & mask) < on_cnt);
    endfunction

endpackage

@@ hw/rtl/spwm_duty_bank.sv @@
// Two frames of channel duties and the parallel per-channel slot compare.
module spwm_duty_bank #(
    parameter int CHANNELS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spwm_pkg::t_duty_wr             i_wr,
    input  logic                           i_frame,
    input  logic [spwm_pkg::SLOT_OUT_W-1:0] i_slot,
    output logic [spwm_pkg::PORT_W-1:0]    o_port_bits
);
    import spwm_pkg::*;

    // Only channels that a 5-bit channel field can reach and the port shows.
    localparam int LANES = (CHANNELS < PORT_W) ? CHANNELS : PORT_W;

    logic [DUTY_W-1:0] r_duty [2][LANES];

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < 2; f++) begin
            for (int c = 0; c < LANES; c++) begin
                if (!i_rst_n) begin
                    r_duty[f][c] <= '0;
                end else if (i_wr.en && (i_wr.frame == 1'(f))
                             && (32'(i_wr.channel) == c)) begin
                    r_duty[f][c] <= i_wr.duty;
                end
            end
        end
    end

    for (genvar c = 0; c < PORT_W; c++) begin : g_lane
        if (c < LANES) begin : g_on
            assign o_port_bits[c] = pwm_level(r_duty[i_frame][c], i_slot);
        end else begin : g_off
            assign o_port_bits[c] = 1'b0;
        end
    end

endmodule

@@ hw/rtl/spwm_frame_ctl.sv @@
// Slot counter and active-frame selection with switch at frame wrap.
module spwm_frame_ctl #(
    parameter int SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spwm_pkg::t_frame_cmd            i_cmd,
    output logic [spwm_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic                            o_frame
);
    import spwm_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);

    logic [SLOT_W-1:0] r_slot;
    logic              r_active;
    logic              r_pending;
    logic              r_target;
    logic              wrap;

    assign wrap = (r_slot == SLOT_W'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_target  <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                if (wrap) begin
                    r_slot <= '0;
                    if (r_pending) begin
                        r_active  <= r_target;
                        r_pending <= 1'b0;
                    end
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            if (i_cmd.select) begin
                r_pending <= 1'b1;
                r_target  <= i_cmd.target;
            end
        end
    end

    assign o_slot  = SLOT_OUT_W'(r_slot);
    assign o_frame = r_active;

    a_wrap_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick && wrap |=> r_slot == '0)
        else $error("slot did not return to zero after last slot");

    a_pending_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_pending) |-> $past(i_cmd.tick && wrap))
        else $error("frame switch applied away from wrap");

    a_active_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_active != $past(r_active))
        |-> $past(i_cmd.tick && wrap && r_pending))
        else $error("active frame changed without pending switch at wrap");

endmodule

@@ hw/rtl/spread_pwm_32ch_core.sv @@
// Top level of the 32-channel spread PWM: request stage, control and result register.
// A spread PWM for up to 32 visible channels with two duty frames. Each request is
// a tick (emit one slot's 32 output bits from the active frame, then advance the
// slot), a set (store one channel's duty, saturated to 64, in the chosen frame), or
// a select (make a frame active once the slot wraps past the last slot). The block
// takes one request per clock cycle unless a tick is stalled. Requests pass a one-entry
// request register and ticks land in a one-entry result register, so a set or select
// keeps flowing while a result waits, and a tick stalls only when the result register
// is full and not being drained. All channels are evaluated in parallel in a single
// compare per lane, which sets the one-slot-per-cycle rate while results are drained.
// Duty storage resets to zero directly, with no clearing pass after reset.
module spread_pwm_32ch_core #(
    parameter int CHANNELS = 32,
    parameter int SLOTS    = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  spwm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spwm_pkg::t_out_item o_out_item
);
    import spwm_pkg::*;

    // Request register.
    logic     r_in_valid;
    t_in_item r_in;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic                  advance;
    logic                  is_tick;
    t_duty_wr              duty_wr;
    t_frame_cmd            frame_cmd;
    logic [SLOT_OUT_W-1:0] cur_slot;
    logic                  cur_frame;
    logic [PORT_W-1:0]     port_bits;

    assign is_tick = (r_in.action == ACT_TICK);

    // Drain the request stage unless a tick meets a full, stalled result register.
    assign advance    = r_in_valid && (!is_tick || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Decode the held request; unused action code falls through to no effect.
    always_comb begin
        duty_wr   = '0;
        frame_cmd = '0;
        case (r_in.action)
            ACT_TICK: begin
                frame_cmd.tick = advance;
            end
            ACT_SET: begin
                duty_wr.en      = advance && (32'(r_in.channel) < CHANNELS);
                duty_wr.frame   = r_in.buffer_sel;
                duty_wr.channel = r_in.channel;
                duty_wr.duty    = (r_in.duty > 8'(DUTY_FULL)) ? DUTY_FULL
                                                              : r_in.duty[DUTY_W-1:0];
            end
            ACT_SELECT: begin
                frame_cmd.select = advance;
                frame_cmd.target = r_in.buffer_sel;
            end
            default: begin
                duty_wr   = '0;
                frame_cmd = '0;
            end
        endcase
    end

    spwm_frame_ctl #(
        .SLOTS (SLOTS)
    ) u_frame_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (frame_cmd),
        .o_slot  (cur_slot),
        .o_frame (cur_frame)
    );

    spwm_duty_bank #(
        .CHANNELS (CHANNELS)
    ) u_duty_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (duty_wr),
        .i_frame     (cur_frame),
        .i_slot      (cur_slot),
        .o_port_bits (port_bits)
    );

    // Capture the pattern of the current slot before the counter advances.
    always_comb begin
        n_out.port_bits  = port_bits;
        n_out.slot       = cur_slot;
        n_out.frame_used = cur_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(advance && is_tick))
        else $error("result appeared without an accepted tick");

    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && is_tick && r_out_valid && !i_out_ready
        |=> r_in_valid && $stable(r_in))
        else $error("stalled tick request lost or changed");

    a_non_tick_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && r_in_valid && !is_tick |-> advance)
        else $error("set or select request blocked by stalled result");

endmodule

@@ test/tb_spread_pwm_32ch_core.sv @@
// Self-checking testbench for the 32-channel spread PWM core with a built-in slot predictor.
module tb_spread_pwm_32ch_core;
    timeunit 1ns;
    timeprecision 1ps;

    import spwm_pkg::*;

    localparam int NUM_CH      = 32;
    localparam int NUM_SLOTS   = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;
    localparam int RAND_PER_PHASE = 220;

    // The package names three request codes; the fourth is unused and ignored.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_taken  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item out_item;

    // Requests waiting to be driven, and slot patterns waiting to be seen.
    t_in_item  pending_reqs[$];
    t_out_item expected_slots[$];

    // Idle and stall odds in percent, changed between phases.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned n_ticks       = 0;
    int unsigned n_sets        = 0;
    int unsigned n_selects     = 0;
    int unsigned n_ignored     = 0;
    int unsigned n_results     = 0;
    int unsigned n_switches    = 0;

    // Predictor state: both duty frames, slot position and the frame switch request.
    bit [6:0]    duty_frames[2][NUM_CH];
    int unsigned slot_now       = 0;
    bit          frame_now      = 1'b0;
    bit          switch_armed   = 1'b0;
    bit          switch_frame   = 1'b0;

    spread_pwm_32ch_core #(
        .CHANNELS(NUM_CH),
        .SLOTS   (NUM_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Level of one channel: the on-time is spread over periods of 64 >> ctz(duty).
    function automatic bit channel_is_high(bit [6:0] duty, int unsigned slot);
        int unsigned e;
        bit [6:0]    d;
        int unsigned period;
        int unsigned on_cnt;
        if (duty >= DUTY_FULL) return 1'b1;
        d = duty;
        e = 0;
        while (e < 6 && d[0] == 1'b0) begin
            d = d >> 1;
            e++;
        end
        period = 64 >> e;
        on_cnt = duty >> e;
        return (slot % period) < on_cnt;
    endfunction

    // Advance the predictor by one accepted request; a tick queues its slot pattern.
    task automatic predict_request(input t_in_item req);
        t_out_item want;
        case (req.action)
            ACT_TICK: begin
                want.port_bits = '0;
                for (int c = 0; c < NUM_CH && c < PORT_W; c++) begin
                    want.port_bits[c] = channel_is_high(duty_frames[frame_now][c], slot_now);
                end
                want.slot       = slot_now[SLOT_OUT_W-1:0];
                want.frame_used = frame_now;
                expected_slots.push_back(want);
                n_ticks++;
                // Wrap past the last slot; a pending select lands here.
                if (slot_now + 1 >= NUM_SLOTS) begin
                    slot_now = 0;
                    if (switch_armed) begin
                        frame_now    = switch_frame;
                        switch_armed = 1'b0;
                        n_switches++;
                    end
                end else begin
                    slot_now++;
                end
            end
            ACT_SET: begin
                if (req.channel < NUM_CH) begin
                    duty_frames[req.buffer_sel][req.channel] =
                        (req.duty > DUTY_FULL) ? DUTY_FULL : req.duty[6:0];
                end
                n_sets++;
            end
            ACT_SELECT: begin
                // A later select before the wrap overrides the earlier one.
                switch_armed = 1'b1;
                switch_frame = req.buffer_sel;
                n_selects++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0d] mismatch %s: got 0x%08h, want 0x%08h", cycle_count, what, got, want);
        end
        error_count++;
    endtask

    function automatic t_in_item make_req(logic [1:0] act, logic sel, logic [4:0] ch,
                                          logic [7:0] duty);
        t_in_item r;
        r.action     = act;
        r.buffer_sel = sel;
        r.channel    = ch;
        r.duty       = duty;
        return r;
    endfunction

    // Mostly ticks so the slot wraps often, with frequent duty writes, a few
    // selects and some unused codes. Duties lean on the edges of the encoding.
    function automatic t_in_item make_random_req();
        t_in_item    r;
        int unsigned pick;
        int unsigned dpick;
        r     = t_in_item'($urandom);
        pick  = $urandom_range(0, 99);
        dpick = $urandom_range(0, 9);
        if (pick < 62) begin
            r.action = ACT_TICK;
        end else if (pick < 90) begin
            r.action = ACT_SET;
        end else if (pick < 96) begin
            r.action = ACT_SELECT;
        end else begin
            r.action = ACT_UNUSED;
        end
        case (dpick)
            0: r.duty = 8'd0;
            1: r.duty = 8'd64;
            2: r.duty = 8'd1 << $urandom_range(0, 7);
            3: r.duty = 8'(64 + $urandom_range(0, 191));
            4: r.duty = 8'(63 - $urandom_range(0, 2));
            default: r.duty = 8'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    // Driver: present the next request at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= pending_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: check taken results against the oldest prediction, then predict.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_slots.size());
            $display("simulation failed");
            $finish;
        end else begin
            in_taken <= i_rst_n && in_valid && o_in_ready;
            if (i_rst_n && o_out_valid && out_ready) begin
                n_results++;
                if (expected_slots.size() == 0) begin
                    report_mismatch("unexpected result", out_item.port_bits, '0);
                end else begin
                    want = expected_slots.pop_front();
                    if (out_item.port_bits !== want.port_bits)
                        report_mismatch("port_bits", out_item.port_bits, want.port_bits);
                    if (out_item.slot !== want.slot)
                        report_mismatch("slot", 32'(out_item.slot), 32'(want.slot));
                    if (out_item.frame_used !== want.frame_used)
                        report_mismatch("frame_used", 32'(out_item.frame_used),
                                        32'(want.frame_used));
                end
            end
            if (i_rst_n && in_valid && o_in_ready) predict_request(in_item);
        end
    end

    initial begin : stimulus
        int unsigned idle_pct[4];
        int unsigned stall_pct[4];
        idle_pct  = '{0, 65, 0, 34};
        stall_pct = '{0, 0, 65, 34};

        for (int f = 0; f < 2; f++)
            for (int c = 0; c < NUM_CH; c++)
                duty_frames[f][c] = '0;

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset pattern, duty edges, saturation, unused code,
        // repeated selects and a write to the frame in use.
        pending_reqs.push_back(make_req(ACT_TICK,   1'b0, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd0,  8'd64));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd31, 8'd255));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd1,  8'd1));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd2,  8'd63));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd3,  8'd32));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd4,  8'd48));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd5,  8'd65));
        pending_reqs.push_back(make_req(ACT_SET,    1'b1, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SET,    1'b1, 5'd7,  8'd2));
        pending_reqs.push_back(make_req(ACT_TICK,   1'b1, 5'd31, 8'd255));
        pending_reqs.push_back(make_req(ACT_UNUSED, 1'b1, 5'd31, 8'd255));
        pending_reqs.push_back(make_req(ACT_TICK,   1'b0, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SELECT, 1'b1, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SELECT, 1'b0, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SELECT, 1'b1, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SET,    1'b1, 5'd31, 8'd127));
        pending_reqs.push_back(make_req(ACT_TICK,   1'b0, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_SET,    1'b0, 5'd0,  8'd0));
        pending_reqs.push_back(make_req(ACT_TICK,   1'b0, 5'd0,  8'd0));

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int i = 0; i < RAND_PER_PHASE; i++) pending_reqs.push_back(make_random_req());
            // Drain the phase: sender stays quiet until every slot pattern is back.
            while (pending_reqs.size() != 0 || in_valid) @(posedge i_clk);
            while (expected_slots.size() != 0) @(posedge i_clk);
        end

        // Let the pipeline settle so a stray result would still show up.
        repeat (10) @(posedge i_clk);

        $display("ran %0d ticks, %0d duty writes, %0d selects, %0d unused codes",
                 n_ticks, n_sets, n_selects, n_ignored);
        $display("checked %0d slot results across %0d frame switches, %0d mismatches",
                 n_results, n_switches, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/spwm_pkg.sv
hw/rtl/spwm_duty_bank.sv
hw/rtl/spwm_frame_ctl.sv
hw/rtl/spread_pwm_32ch_core.sv
test/tb_spread_pwm_32ch_core.sv
